// ===== src/sbms_pkg.sv =====
// ----------------------------------------------------------------------------
// sbms_pkg
// Shared types and constants for the multi-stack shared buffer.
// ----------------------------------------------------------------------------
package sbms_pkg;

    localparam int NUM_STACKS = 4;
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(DEPTH + 1);
    localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    localparam int CMD_W  = 2;
    localparam int SID_W  = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// ===== src/sbms_if.sv =====
// ----------------------------------------------------------------------------
// sbms_if
// Valid/ready channels for commands into and results out of the buffer.
// ----------------------------------------------------------------------------
interface sbms_in_if;
    logic                                     valid;
    logic                                     ready;
    logic        [sbms_pkg::CMD_W-1:0]        command;
    logic        [sbms_pkg::SID_W-1:0]        stack_id;
    logic signed [sbms_pkg::VAL_W-1:0]        value;

    modport source (output valid, output command, output stack_id, output value,
                    input ready);
    modport sink   (input valid, input command, input stack_id, input value,
                    output ready);
endinterface

interface sbms_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [sbms_pkg::VAL_W-1:0]        data;
    logic        [sbms_pkg::STAT_W-1:0]       status;

    modport source (output valid, output data, output status, input ready);
    modport sink   (input valid, input data, input status, output ready);
endinterface

// ===== src/sbms_ram.sv =====
// ----------------------------------------------------------------------------
// sbms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/shared_buffer_multi_stack.sv =====
// ----------------------------------------------------------------------------
// shared_buffer_multi_stack
// Several LIFO stacks sharing one data memory through a linked free list.
//
// Commands arrive on the i_in channel: push, pop or peek on one stack.
// Every command produces exactly one result transfer on o_out with the
// popped or peeked word and a status of ok, full or empty.
// A command is taken in the idle state, which reads the link and data
// memories at the free-list head or the stack top. In the execute state,
// once the output register is free, the result is written into it together
// with the write-back of the link and data memories and the head registers,
// a read-then-write-back on the link memory. The result is valid on o_out
// from the cycle after the execute cycle.
// A new command is accepted while a finished result still waits on o_out.
// If the receiver stalls, the block holds its next result in the execute
// state until the output register frees up, and accepts nothing meanwhile.
// Reset empties all stacks and puts every slot on the free list at once;
// slots beyond the fill count read their initial link, so no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module shared_buffer_multi_stack (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbms_in_if.sink    i_in,
    sbms_out_if.source o_out
);

    localparam int AW = sbms_pkg::ADDR_W;
    localparam int SW = sbms_pkg::SLOT_W;
    localparam int DW = sbms_pkg::DATA_WIDTH;
    localparam int KW = sbms_pkg::STK_W;

    sbms_pkg::t_state r_state;
    sbms_pkg::t_state n_state;

    logic [SW-1:0] r_heads [sbms_pkg::NUM_STACKS];
    logic [SW-1:0] r_free_head;
    logic [SW-1:0] n_free_head;
    logic [SW-1:0] r_fill;
    logic [SW-1:0] n_fill;

    logic [sbms_pkg::CMD_W-1:0] r_cmd;
    logic [KW-1:0]              r_sid;
    logic                       r_sid_ok;
    logic [DW-1:0]              r_value;
    logic [SW-1:0]              r_slot;

    logic                             r_out_valid;
    logic signed [sbms_pkg::VAL_W-1:0] r_out_data;
    logic [sbms_pkg::STAT_W-1:0]      r_out_status;

    logic          w_accept;
    logic          w_out_free;
    logic          w_commit;
    logic [KW-1:0] w_sid;
    logic [SW-1:0] w_slot;
    logic          w_slot_ok;
    logic [SW-1:0] w_link;

    logic          w_head_we;
    logic [SW-1:0] w_head_val;
    logic          w_link_we;
    logic [SW-1:0] w_link_wdata;
    logic          w_data_we;
    logic [SW-1:0] w_link_rdata;
    logic [DW-1:0] w_data_rdata;

    logic signed [sbms_pkg::VAL_W-1:0] w_res_data;
    logic [sbms_pkg::STAT_W-1:0]       w_res_status;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_commit   = (r_state == sbms_pkg::S_EXEC) && w_out_free;
    assign w_sid      = KW'(i_in.stack_id);
    assign w_slot     = (i_in.command == sbms_pkg::CMD_PUSH) ? r_free_head : r_heads[w_sid];
    assign w_slot_ok  = r_slot < sbms_pkg::NULL_SLOT;
    assign w_link     = (r_slot >= r_fill) ? (r_slot + SW'(1)) : w_link_rdata;

    assign i_in.ready   = (r_state == sbms_pkg::S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out_data;
    assign o_out.status = r_out_status;

    sbms_ram #(
        .WIDTH (SW),
        .DEPTH (sbms_pkg::DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (r_slot[AW-1:0]),
        .i_wdata (w_link_wdata),
        .i_re    (w_accept),
        .i_raddr (w_slot[AW-1:0]),
        .o_rdata (w_link_rdata)
    );

    sbms_ram #(
        .WIDTH (DW),
        .DEPTH (sbms_pkg::DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (r_slot[AW-1:0]),
        .i_wdata (r_value),
        .i_re    (w_accept),
        .i_raddr (w_slot[AW-1:0]),
        .o_rdata (w_data_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbms_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = sbms_pkg::S_EXEC;
                end
            end
            sbms_pkg::S_EXEC: begin
                if (w_out_free) begin
                    n_state = sbms_pkg::S_IDLE;
                end
            end
            default: n_state = sbms_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_free_head  = r_free_head;
        n_fill       = r_fill;
        w_head_we    = 1'b0;
        w_head_val   = w_link;
        w_link_we    = 1'b0;
        w_link_wdata = r_free_head;
        w_data_we    = 1'b0;
        w_res_data   = '0;
        w_res_status = sbms_pkg::ST_OK;
        if (r_state == sbms_pkg::S_EXEC) begin
            case (r_cmd)
                sbms_pkg::CMD_PUSH: begin
                    if (!r_sid_ok || !w_slot_ok) begin
                        w_res_status = sbms_pkg::ST_FULL;
                    end else begin
                        n_free_head  = w_link;
                        w_data_we    = w_commit;
                        w_link_we    = w_commit;
                        w_link_wdata = r_heads[r_sid];
                        w_head_we    = w_commit;
                        w_head_val   = r_slot;
                        if (r_slot == r_fill) begin
                            n_fill = r_fill + SW'(1);
                        end
                    end
                end
                sbms_pkg::CMD_POP, sbms_pkg::CMD_PEEK: begin
                    if (!r_sid_ok || !w_slot_ok) begin
                        w_res_status = sbms_pkg::ST_EMPTY;
                    end else begin
                        w_res_data = sbms_pkg::VAL_W'($signed(w_data_rdata));
                        if (r_cmd == sbms_pkg::CMD_POP) begin
                            n_free_head  = r_slot;
                            w_link_we    = w_commit;
                            w_link_wdata = r_free_head;
                            w_head_we    = w_commit;
                            w_head_val   = w_link;
                        end
                    end
                end
                default: begin
                    w_res_status = sbms_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbms_pkg::S_IDLE;
            r_free_head <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < sbms_pkg::NUM_STACKS; i++) begin
                r_heads[i] <= sbms_pkg::NULL_SLOT;
            end
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_free_head <= n_free_head;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
                if (w_head_we) begin
                    r_heads[r_sid] <= w_head_val;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_in.command;
            r_sid    <= w_sid;
            r_sid_ok <= 32'(i_in.stack_id) < sbms_pkg::NUM_STACKS;
            r_value  <= DW'(i_in.value);
            r_slot   <= w_slot;
        end
        if (w_commit) begin
            r_out_data   <= w_res_data;
            r_out_status <= w_res_status;
        end
    end

    a_free_head_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= r_fill)
        else $error("Free-list head lies beyond the fill count.");

    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == sbms_pkg::S_EXEC) && !i_in.ready)
        else $error("Accepted command did not move to the execute state.");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == sbms_pkg::S_EXEC)
        else $error("Result appeared without an executed command.");

endmodule
